// ===== rtl/core/bdhr_pkg.sv =====
`timescale 1ns / 1ps

package bdhr_pkg;

  localparam int unsigned BUTTONS = 3;
  localparam int unsigned IdxW    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int unsigned PinW    = 3;
  localparam int unsigned IdW     = 2;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned StampW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [1:0] STAGE_RELEASED = 2'd0;
  localparam logic [1:0] STAGE_PRESSED  = 2'd1;
  localparam logic [1:0] STAGE_HOLD     = 2'd2;
  localparam logic [1:0] STAGE_LOCKED   = 2'd3;

  localparam logic [CodeW-1:0] EV_PRESS   = 2'd0;
  localparam logic [CodeW-1:0] EV_HOLD    = 2'd1;
  localparam logic [CodeW-1:0] EV_REPEAT  = 2'd2;
  localparam logic [CodeW-1:0] EV_RELEASE = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_HOLD_DELAY   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FLIP         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_HIGH  = 3'd4;

  typedef struct packed {
    logic [StampW-1:0] hold_delay;
    logic [StampW-1:0] repeat_delay;
    logic [CountW-1:0] debounce_count;
    logic              flip_order;
    logic [PinW-1:0]   active_high_mask;
  } cfg_t;

  // Debounced view of one pin after the current tick.
  typedef struct packed {
    logic known;
    logic stable;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic [IdW-1:0]   id;
  } event_t;

endpackage

// ===== rtl/core/bdhr_lane.sv =====
`timescale 1ns / 1ps

module bdhr_lane
  import bdhr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              level_i,
  input  logic [CountW-1:0] debounce_count_i,
  output lane_t             lane_o
);

  logic              last_q, last_d;
  logic [CountW-1:0] steady_q, steady_d;
  logic              known_q, known_d;
  logic              stable_q, stable_d;
  logic [CountW-1:0] steady_inc;

  assign steady_inc = steady_q + CountW'(1);

  always_comb begin
    last_d   = last_q;
    steady_d = steady_q;
    known_d  = known_q;
    stable_d = stable_q;
    if (tick_i) begin
      if (level_i != last_q) begin
        last_d   = level_i;
        steady_d = '0;
      end else if (steady_inc >= debounce_count_i) begin
        // Accepted; the counter restarts so a steady level is re-accepted later.
        stable_d = level_i;
        known_d  = 1'b1;
        steady_d = '0;
      end else begin
        steady_d = steady_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      steady_q <= '0;
      known_q  <= 1'b0;
      stable_q <= 1'b0;
    end else begin
      last_q   <= last_d;
      steady_q <= steady_d;
      known_q  <= known_d;
      stable_q <= stable_d;
    end
  end

  // The scan sees the level as it stands after this tick's update.
  assign lane_o = '{known: known_d, stable: stable_d};

  a_known_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q |=> known_q)
    else $error("debounced level became unknown again");

endmodule

// ===== rtl/core/bdhr_scan.sv =====
`timescale 1ns / 1ps

module bdhr_scan
  import bdhr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 lock_i,
  input  lane_t [BUTTONS-1:0]  lanes_i,
  input  cfg_t                 cfg_i,
  output event_t               event_o
);

  logic [1:0]        stage_q [BUTTONS];
  logic [StampW-1:0] stamp_q [BUTTONS];
  logic [StampW-1:0] tick_q, tick_d;
  logic [IdxW-1:0]   scan_q, scan_d;

  logic [BUTTONS-1:0] active_high;
  lane_t              sel;
  logic               pressed;
  logic [StampW-1:0]  elapsed;
  logic [1:0]         stage_new;
  logic               stamp_wr;
  logic [IdxW-1:0]    rid;
  event_t             ev;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_hi
    if (i < PinW) begin : g_mask
      assign active_high[i] = cfg_i.active_high_mask[i];
    end else begin : g_low
      assign active_high[i] = 1'b0;
    end
  end

  assign tick_d  = tick_q + StampW'(1);
  assign scan_d  = (scan_q == IdxW'(BUTTONS - 1)) ? '0 : scan_q + IdxW'(1);
  assign sel     = lanes_i[scan_q];
  assign pressed = active_high[scan_q] ? sel.stable : ~sel.stable;
  assign elapsed = tick_d - stamp_q[scan_q];
  assign rid     = cfg_i.flip_order ? IdxW'(BUTTONS - 1) - scan_q : scan_q;

  always_comb begin
    stage_new = stage_q[scan_q];
    stamp_wr  = 1'b0;
    ev        = '{valid: 1'b0, code: EV_PRESS, id: IdW'(rid)};
    if (tick_i && sel.known) begin
      unique case (stage_q[scan_q])
        STAGE_RELEASED: begin
          if (pressed) begin
            stage_new = STAGE_PRESSED;
            stamp_wr  = 1'b1;
            ev.valid  = 1'b1;
            ev.code   = EV_PRESS;
          end
        end
        STAGE_PRESSED: begin
          if (!pressed) begin
            stage_new = STAGE_RELEASED;
            ev.valid  = 1'b1;
            ev.code   = EV_RELEASE;
          end else if (elapsed >= cfg_i.hold_delay) begin
            stage_new = STAGE_HOLD;
            stamp_wr  = 1'b1;
            ev.valid  = 1'b1;
            ev.code   = EV_HOLD;
          end
        end
        STAGE_HOLD: begin
          // Leaving hold is silent.
          if (!pressed) begin
            stage_new = STAGE_RELEASED;
          end else if (elapsed >= cfg_i.repeat_delay) begin
            stamp_wr = 1'b1;
            ev.valid = 1'b1;
            ev.code  = EV_REPEAT;
          end
        end
        default: begin
          if (!pressed) stage_new = STAGE_RELEASED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      scan_q <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        stage_q[i] <= STAGE_RELEASED;
        stamp_q[i] <= '0;
      end
    end else if (lock_i) begin
      for (int i = 0; i < BUTTONS; i++) stage_q[i] <= STAGE_LOCKED;
    end else if (tick_i) begin
      tick_q          <= tick_d;
      scan_q          <= scan_d;
      stage_q[scan_q] <= stage_new;
      if (stamp_wr) stamp_q[scan_q] <= tick_d;
    end
  end

  assign event_o = ev;

  a_lock_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_i |=> (stage_q[0] == STAGE_LOCKED && stage_q[BUTTONS-1] == STAGE_LOCKED))
    else $error("lock request did not lock every button");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && !lock_i) |=> tick_q == $past(tick_q) + StampW'(1))
    else $error("tick counter did not advance by one");

  a_event_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.valid |-> (tick_i && sel.known))
    else $error("event raised for a button whose level is unknown");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= IdxW'(BUTTONS - 1))
    else $error("scan index out of range");

endmodule

// ===== rtl/core/button_debounce_hold_repeat_core.sv =====
`timescale 1ns / 1ps
// Channel  | Signals        | Contents (lowest bit first)
// s_axis   | tdata, tuser   | tdata: pin_levels[2:0]; tuser: action
// m_axis   | tdata, tuser   | tdata: button_id[1:0]; tuser: event_code[1:0]
// cfg      | we, index, data| write-only register port, indices 0..4
//
// Pins are debounced in per-button lanes and the scanned button's stage is
// updated in the same cycle, so requests may arrive on every clock while input
// ready is high. At most one event per request goes to a two-entry output
// buffer; input ready falls only when both entries hold an untaken event.
// Reset clears all state but the output buffer's data and loads the register defaults.

module button_debounce_hold_repeat_core
  import bdhr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // pin_levels[2:0], zero fill
  input  logic [0:0]         s_axis_tuser_i,   // action
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // button_id[1:0], zero fill
  output logic [CodeW-1:0]   m_axis_tuser_o,   // event_code[1:0]
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t                cfg_q;
  logic                accept, tick, lock;
  lane_t [BUTTONS-1:0] lanes;
  event_t              ev;

  logic                      out_valid_q, skid_valid_q;
  logic [CodeW+IdW-1:0]      out_q, skid_q, push_data;
  logic                      push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_delay       <= StampW'(1000);
      cfg_q.repeat_delay     <= StampW'(100);
      cfg_q.debounce_count   <= CountW'(10);
      cfg_q.flip_order       <= 1'b0;
      cfg_q.active_high_mask <= PinW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HOLD_DELAY:   cfg_q.hold_delay       <= cfg_wdata_i[StampW-1:0];
        CFG_REPEAT_DELAY: cfg_q.repeat_delay     <= cfg_wdata_i[StampW-1:0];
        CFG_DEBOUNCE:     cfg_q.debounce_count   <= cfg_wdata_i[CountW-1:0];
        CFG_FLIP:         cfg_q.flip_order       <= cfg_wdata_i[0];
        CFG_ACTIVE_HIGH:  cfg_q.active_high_mask <= cfg_wdata_i[PinW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign tick   = accept & ~s_axis_tuser_i[0];
  assign lock   = accept & s_axis_tuser_i[0];

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic level;
    if (i < PinW) begin : g_pin
      assign level = s_axis_tdata_i[i];
    end else begin : g_nopin
      assign level = 1'b0;
    end
    bdhr_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .tick_i           (tick),
      .level_i          (level),
      .debounce_count_i (cfg_q.debounce_count),
      .lane_o           (lanes[i])
    );
  end

  bdhr_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .lock_i  (lock),
    .lanes_i (lanes),
    .cfg_i   (cfg_q),
    .event_o (ev)
  );

  assign push      = ev.valid;
  assign push_data = {ev.code, ev.id};
  assign pop       = out_valid_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= push_data;
      end else begin
        out_q  <= push_data;
      end
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  assign s_axis_tready_o = ~skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q[CodeW+IdW-1:IdW];
  assign m_axis_tdata_o  = {{(8-IdW){1'b0}}, out_q[IdW-1:0]};

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !pop) |=> skid_valid_q)
    else $error("event lost while output stalled");

  a_lock_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock |-> !push)
    else $error("lock request produced an event");

endmodule
